@@ src/ring_buffer_deque_top_defines.svh @@
`ifndef RING_BUFFER_DEQUE_TOP_DEFINES_SVH
`define RING_BUFFER_DEQUE_TOP_DEFINES_SVH

// same-cycle implication, off while reset is held
`define RBD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// next-cycle implication, off while reset is held
`define RBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

@@ src/rbd_pkg.sv @@
`timescale 1ns / 1ps

package rbd_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_TAIL = 3'd0,
    CMD_PUSH_HEAD = 3'd1,
    CMD_POP_TAIL  = 3'd2,
    CMD_POP_HEAD  = 3'd3,
    CMD_READ_IDX  = 3'd4,
    CMD_WRITE_IDX = 3'd5
  } rbd_cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADIDX = 2'd3
  } rbd_status_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [3:0]  index;
    logic [31:0] value_in;
  } rbd_in_t;

  typedef struct packed {
    logic [31:0] value_out;
    logic [4:0]  count;
    logic [1:0]  status;
  } rbd_out_t;

  // classified request handed from the front to the back
  typedef struct packed {
    logic        mem_rd;
    logic        mem_wr;
    logic [31:0] value;
    logic [4:0]  count;
    rbd_status_e status;
  } rbd_op_t;

endpackage

@@ src/rbd_front.sv @@
`timescale 1ns / 1ps

module rbd_front #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  rbd_pkg::rbd_in_t in_i,
  input  logic             q_full_i,
  output logic             push_o,
  output rbd_pkg::rbd_op_t op_o,
  output logic [AW-1:0]    slot_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (CW > 4) ? CW : 4;

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic          full, empty, idx_ok;
  logic [31:0]   val;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign push_o = in_valid_i && !q_full_i;

  assign full   = (count_q == CW'(DEPTH));
  assign empty  = (count_q == '0);
  assign idx_ok = (IW'(in_i.index) < IW'(count_q));
  // element kept at the store width
  assign val    = 32'(DATA_WIDTH'(in_i.value_in));

  always_comb begin
    head_d       = head_q;
    count_d      = count_q;
    slot_o       = '0;
    op_o.mem_rd  = 1'b0;
    op_o.mem_wr  = 1'b0;
    op_o.value   = '0;
    op_o.status  = rbd_pkg::ST_OK;
    case (in_i.command)
      rbd_pkg::CMD_PUSH_TAIL: begin
        if (full) begin
          op_o.status = rbd_pkg::ST_FULL;
        end else begin
          slot_o      = wrap_add(head_q, AW'(count_q));
          op_o.mem_wr = 1'b1;
          op_o.value  = val;
          count_d     = count_q + CW'(1);
        end
      end
      rbd_pkg::CMD_PUSH_HEAD: begin
        if (full) begin
          op_o.status = rbd_pkg::ST_FULL;
        end else begin
          head_d      = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
          slot_o      = head_d;
          op_o.mem_wr = 1'b1;
          op_o.value  = val;
          count_d     = count_q + CW'(1);
        end
      end
      rbd_pkg::CMD_POP_TAIL: begin
        if (empty) begin
          op_o.status = rbd_pkg::ST_EMPTY;
        end else begin
          count_d     = count_q - CW'(1);
          slot_o      = wrap_add(head_q, AW'(count_d));
          op_o.mem_rd = 1'b1;
        end
      end
      rbd_pkg::CMD_POP_HEAD: begin
        if (empty) begin
          op_o.status = rbd_pkg::ST_EMPTY;
        end else begin
          slot_o      = head_q;
          head_d      = wrap_add(head_q, AW'(1));
          count_d     = count_q - CW'(1);
          op_o.mem_rd = 1'b1;
        end
      end
      rbd_pkg::CMD_READ_IDX: begin
        if (!idx_ok) begin
          op_o.status = rbd_pkg::ST_BADIDX;
        end else begin
          slot_o      = wrap_add(head_q, AW'(in_i.index));
          op_o.mem_rd = 1'b1;
        end
      end
      rbd_pkg::CMD_WRITE_IDX: begin
        if (!idx_ok) begin
          op_o.status = rbd_pkg::ST_BADIDX;
        end else begin
          // old value comes back through the read port in the same access
          slot_o      = wrap_add(head_q, AW'(in_i.index));
          op_o.mem_rd = 1'b1;
          op_o.mem_wr = 1'b1;
          op_o.value  = val;
        end
      end
      default: begin
      end
    endcase
    op_o.count = 5'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (push_o) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

endmodule

@@ src/rbd_queue.sv @@
`timescale 1ns / 1ps

module rbd_queue #(
  parameter int AW = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rbd_pkg::rbd_op_t op_i,
  input  logic [AW-1:0]    slot_i,
  output logic             full_o,
  output logic             valid_o,
  output rbd_pkg::rbd_op_t op_o,
  output logic [AW-1:0]    slot_o,
  input  logic             pop_i
);

  rbd_pkg::rbd_op_t op_q   [2];
  logic [AW-1:0]    slot_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign op_o    = op_q[rd_q];
  assign slot_o  = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      op_q[wr_q]   <= op_i;
      slot_q[wr_q] <= slot_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ src/rbd_back.sv @@
`timescale 1ns / 1ps

module rbd_back #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  rbd_pkg::rbd_op_t  op_i,
  input  logic [AW-1:0]     slot_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rbd_pkg::rbd_out_t out_o
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;
  rbd_pkg::rbd_op_t      meta_q;
  logic                  out_valid_q;

  // take the next request whenever the output register is free or draining
  assign pop_o = valid_i && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i) begin
    if (pop_o && op_i.mem_wr) begin
      mem[slot_i] <= DATA_WIDTH'(op_i.value);
    end
    if (pop_o && op_i.mem_rd) begin
      rdata_q <= mem[slot_i];
    end
    if (pop_o) begin
      meta_q <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_o.value_out = meta_q.mem_rd ? 32'(rdata_q) : meta_q.value;
  assign out_o.count     = meta_q.count;
  assign out_o.status    = meta_q.status;

endmodule

@@ src/ring_buffer_deque_top.sv @@
`timescale 1ns / 1ps

// Fixed-capacity double-ended queue of DEPTH elements in a circular store.
// Each request pushes or pops at either end, or reads or overwrites the
// element at a logical index from the head, and gives exactly one result with
// a value, the count after the request and a status (ok, full, empty, index
// out of range). Requests are taken at one per cycle unless the input stalls;
// each is held in the queue, then registered in the back's output register,
// where its result is presented. The front updates the head pointer
// and count in the cycle a request is accepted; the back makes one access to
// the single-port-read, single-port-write store per request, which together
// with the pointer update sets the one-per-cycle rate. A two-entry queue
// between them absorbs output stalls before the input stalls.
module ring_buffer_deque_top #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rbd_pkg::rbd_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rbd_pkg::rbd_out_t out_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic             q_full, q_push, q_valid, q_pop;
  rbd_pkg::rbd_op_t f_op, b_op;
  logic [AW-1:0]    f_slot, b_slot;

  assign in_stall_o = q_full;

  rbd_front #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_i       (in_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .op_o       (f_op),
    .slot_o     (f_slot)
  );

  rbd_queue #(
    .AW (AW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .op_i    (f_op),
    .slot_i  (f_slot),
    .full_o  (q_full),
    .valid_o (q_valid),
    .op_o    (b_op),
    .slot_o  (b_slot),
    .pop_i   (q_pop)
  );

  rbd_back #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .op_i        (b_op),
    .slot_i      (b_slot),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

@@ src/rbd_checker.sv @@
`timescale 1ns / 1ps

`include "ring_buffer_deque_top_defines.svh"

module rbd_checker #(
  parameter int DEPTH = 16
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input rbd_pkg::rbd_out_t out_o
);

  logic out_full, out_empty, out_held, in_held;

  assign out_full  = out_valid_o && (out_o.status == rbd_pkg::ST_FULL);
  assign out_empty = out_valid_o && (out_o.status == rbd_pkg::ST_EMPTY);
  assign out_held  = out_valid_o && out_stall_i;
  assign in_held   = in_valid_i && in_stall_o;

  // a refused push only happens at capacity
  `RBD_ASSERT_IMPL(a_full_at_cap, clk_i, rst_ni, out_full, out_o.count == 5'(DEPTH))
  // a refused pop only happens with nothing held
  `RBD_ASSERT_IMPL(a_empty_at_zero, clk_i, rst_ni, out_empty, out_o.count == 5'd0)
  // a stalled result stays and keeps its payload
  `RBD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(out_o))
  // the input only stalls behind a waiting result
  `RBD_ASSERT_IMPL(a_stall_backed, clk_i, rst_ni, in_held, out_valid_o)

endmodule

bind ring_buffer_deque_top rbd_checker #(.DEPTH(DEPTH)) u_rbd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_o       (out_o)
);

@@ tb/ring_buffer_deque_checker.sv @@
`timescale 1ns / 1ps

module ring_buffer_deque_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  rbd_pkg::rbd_in_t  in_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  rbd_pkg::rbd_out_t out_i,
  output int                fail_count_o,
  output int                pending_o
);

  localparam int DEPTH = 16;

  // shadow copy of the deque
  logic [31:0] ring_mem [DEPTH];
  logic [3:0]  head_ptr;
  logic [4:0]  held;

  rbd_pkg::rbd_out_t awaited_results [$];
  int                errors = 0;
  int                waiting = 0;
  int                result_num = 0;

  assign fail_count_o = errors;
  assign pending_o    = waiting;

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch on result %0d: %s", $time, result_num, msg);
    errors++;
  endtask

  function automatic rbd_pkg::rbd_out_t apply_request(input rbd_pkg::rbd_in_t req);
    rbd_pkg::rbd_out_t res;
    logic [3:0]        slot;
    res = '0;
    res.status = rbd_pkg::ST_OK;
    case (req.command)
      rbd_pkg::CMD_PUSH_TAIL: begin
        if (held == DEPTH) begin
          res.status = rbd_pkg::ST_FULL;
        end else begin
          slot = head_ptr + held[3:0];
          ring_mem[slot] = req.value_in;
          held++;
          res.value_out = req.value_in;
        end
      end
      rbd_pkg::CMD_PUSH_HEAD: begin
        if (held == DEPTH) begin
          res.status = rbd_pkg::ST_FULL;
        end else begin
          head_ptr = head_ptr - 4'd1;
          ring_mem[head_ptr] = req.value_in;
          held++;
          res.value_out = req.value_in;
        end
      end
      rbd_pkg::CMD_POP_TAIL: begin
        if (held == 0) begin
          res.status = rbd_pkg::ST_EMPTY;
        end else begin
          held--;
          slot = head_ptr + held[3:0];
          res.value_out = ring_mem[slot];
        end
      end
      rbd_pkg::CMD_POP_HEAD: begin
        if (held == 0) begin
          res.status = rbd_pkg::ST_EMPTY;
        end else begin
          res.value_out = ring_mem[head_ptr];
          head_ptr = head_ptr + 4'd1;
          held--;
        end
      end
      rbd_pkg::CMD_READ_IDX: begin
        if ({1'b0, req.index} >= held) begin
          res.status = rbd_pkg::ST_BADIDX;
        end else begin
          slot = head_ptr + req.index;
          res.value_out = ring_mem[slot];
        end
      end
      rbd_pkg::CMD_WRITE_IDX: begin
        if ({1'b0, req.index} >= held) begin
          res.status = rbd_pkg::ST_BADIDX;
        end else begin
          slot = head_ptr + req.index;
          res.value_out = ring_mem[slot];
          ring_mem[slot] = req.value_in;
        end
      end
      default: ;  // spare codes leave everything alone
    endcase
    res.count = held;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rbd_pkg::rbd_out_t exp_res;
    if (!rst_ni) begin
      head_ptr = '0;
      held     = '0;
      awaited_results.delete();
      waiting = 0;
    end else begin
      // requests first, so a result never races its own prediction
      if (in_valid_i && !in_stall_i) awaited_results.push_back(apply_request(in_i));
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          exp_res = awaited_results.pop_front();
          if (out_i.value_out !== exp_res.value_out)
            report_mismatch($sformatf("value_out %h, expected %h",
                                      out_i.value_out, exp_res.value_out));
          if (out_i.count !== exp_res.count)
            report_mismatch($sformatf("count %0d, expected %0d",
                                      out_i.count, exp_res.count));
          if (out_i.status !== exp_res.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_i.status, exp_res.status));
        end
        result_num++;
      end
      waiting = awaited_results.size();
    end
  end

endmodule

@@ tb/ring_buffer_deque_top_tb.sv @@
`timescale 1ns / 1ps

module ring_buffer_deque_top_tb;

  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam int         RANDOM_REQS  = 1950;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} mix_mode_e;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  rbd_pkg::rbd_in_t  in_req;
  logic              out_valid;
  logic              out_stall;
  rbd_pkg::rbd_out_t out_res;
  logic              in_taken;
  bit                quiet;
  int                fail_count;
  int                pending;

  ring_buffer_deque_top i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_i       (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_o      (out_res)
  );

  ring_buffer_deque_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_i        (in_req),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_i       (out_res),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // acceptance seen at the rising edge, read back at the falling edge
  always_ff @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
    end
  end

  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 13);
  end

  function automatic rbd_pkg::rbd_in_t mk_req(input logic [2:0] cmd, input logic [3:0] idx,
                                              input logic [31:0] val);
    rbd_pkg::rbd_in_t req;
    req.command  = cmd;
    req.index    = idx;
    req.value_in = val;
    return req;
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(15);
    if (r == 0) return 32'h0;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic logic [2:0] pick_cmd(input mix_mode_e mode);
    int r;
    int pw;
    int qw;
    r  = $urandom_range(99);
    pw = (mode == MODE_FILL) ? 28 : (mode == MODE_DRAIN) ? 8 : 18;
    qw = (mode == MODE_FILL) ? 8 : (mode == MODE_DRAIN) ? 28 : 18;
    if (r < pw) return rbd_pkg::CMD_PUSH_TAIL;
    if (r < 2 * pw) return rbd_pkg::CMD_PUSH_HEAD;
    if (r < 2 * pw + qw) return rbd_pkg::CMD_POP_TAIL;
    if (r < 2 * pw + 2 * qw) return rbd_pkg::CMD_POP_HEAD;
    if (r >= 98) return (r == 98) ? CMD_SPARE_LO : CMD_SPARE_HI;
    return (r % 2 == 0) ? rbd_pkg::CMD_READ_IDX : rbd_pkg::CMD_WRITE_IDX;
  endfunction

  task automatic send_request(input rbd_pkg::rbd_in_t req);
    while (!quiet && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(negedge clk); while (!in_taken);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  initial begin
    mix_mode_e mode;
    int        mode_left;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_req    = '0;
    quiet     = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty and near-empty queue corner cases
    send_request(mk_req(rbd_pkg::CMD_POP_TAIL, 4'd0, 32'h0));
    send_request(mk_req(rbd_pkg::CMD_POP_HEAD, 4'd0, 32'h0));
    send_request(mk_req(rbd_pkg::CMD_READ_IDX, 4'd0, 32'h0));
    send_request(mk_req(rbd_pkg::CMD_WRITE_IDX, 4'd0, 32'h1234_5678));
    send_request(mk_req(CMD_SPARE_LO, 4'd15, 32'hFFFF_FFFF));
    send_request(mk_req(CMD_SPARE_HI, 4'd0, 32'h0));
    send_request(mk_req(rbd_pkg::CMD_PUSH_TAIL, 4'd0, 32'hFFFF_FFFF));
    send_request(mk_req(rbd_pkg::CMD_PUSH_HEAD, 4'd0, 32'h0));
    send_request(mk_req(rbd_pkg::CMD_READ_IDX, 4'd1, 32'h0));
    send_request(mk_req(rbd_pkg::CMD_WRITE_IDX, 4'd0, 32'h5A5A_A5A5));
    // fill to capacity, pushing at both ends so the head wraps, then test at full
    for (int i = 0; i < 14; i++)
      send_request(mk_req((i % 2 == 0) ? rbd_pkg::CMD_PUSH_HEAD : rbd_pkg::CMD_PUSH_TAIL,
                          4'd0, $urandom));
    send_request(mk_req(rbd_pkg::CMD_PUSH_TAIL, 4'd0, 32'hDEAD_0001));
    send_request(mk_req(rbd_pkg::CMD_PUSH_HEAD, 4'd0, 32'hDEAD_0002));
    send_request(mk_req(rbd_pkg::CMD_READ_IDX, 4'd15, 32'h0));
    send_request(mk_req(rbd_pkg::CMD_WRITE_IDX, 4'd15, 32'hFFFF_FFFF));
    send_request(mk_req(rbd_pkg::CMD_POP_TAIL, 4'd0, 32'h0));
    send_request(mk_req(rbd_pkg::CMD_POP_HEAD, 4'd0, 32'h0));
    drain_results();

    mode      = MODE_FILL;
    mode_left = 40;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (mode_left == 0) begin
        mode      = mix_mode_e'($urandom_range(2));
        mode_left = $urandom_range(60, 20);
      end
      mode_left--;
      quiet = (n >= 900 && n < 1150);
      if (n == 500 || n == 1500) drain_results();
      send_request(mk_req(pick_cmd(mode), 4'($urandom_range(15)), pick_value()));
    end

    drain_results();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/rbd_pkg.sv
src/rbd_front.sv
src/rbd_queue.sv
src/rbd_back.sv
src/ring_buffer_deque_top.sv
src/rbd_checker.sv
tb/ring_buffer_deque_checker.sv
tb/ring_buffer_deque_top_tb.sv
